// ===== hdl/bsst_pkg.sv =====
// shared types and constants for the bounded set span tracker
package bsst_pkg;

   localparam int BSST_MAX_ENTRIES = 64;
   localparam int BSST_VAL_W       = 32;
   localparam int BSST_CAP_W       = 7;
   localparam logic [BSST_CAP_W-1:0] BSST_CAP_RESET = 7'd64;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SCAN,
      ST_DRAIN,
      ST_COMMIT,
      ST_REPLY
   } bsst_state_type;

   typedef struct packed {
      logic load;
      logic check;
      logic scan;
      logic commit;
   } bsst_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic last;
   } bsst_stat_type;

endpackage

// ===== hdl/bounded_set_span_tracker_top.sv =====
// top level of the bounded set span tracker
// a beat runs through CHECK, SCAN (over every number held), DRAIN, COMMIT and REPLY to the rsp_valid beat;
// an add into an empty set skips SCAN and DRAIN, and a rejected add goes from CHECK straight to REPLY
// the next beat is taken only once the block is back in IDLE after the result
// throughput is set by the single read port of the value store, one compare per cycle
// reset: synchronous, empties the set and sets capacity to 64; the receiver cannot stall
module bounded_set_span_tracker_top
   import bsst_pkg::*;
#(
   parameter int MAX_ENTRIES = BSST_MAX_ENTRIES
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [BSST_VAL_W-1:0] req_value,
   input  logic                  req_start_new,
   output logic                  rsp_valid,
   output logic                  rsp_status,
   output logic [BSST_CAP_W-1:0] rsp_entries_held,
   output logic                  rsp_spans_valid,
   output logic [BSST_VAL_W-1:0] rsp_narrow_span,
   output logic [BSST_VAL_W-1:0] rsp_longest_span,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [BSST_CAP_W-1:0] csr_capacity
);

   bsst_cmd_type  cmd;
   bsst_stat_type stat;

   assign csr_ready = 1'b1;

   bsst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   bsst_dpath #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_value         (req_value),
      .req_start_new     (req_start_new),
      .csr_valid         (csr_valid),
      .csr_capacity      (csr_capacity),
      .rsp_status        (rsp_status),
      .rsp_entries_held  (rsp_entries_held),
      .rsp_spans_valid   (rsp_spans_valid),
      .rsp_narrow_span   (rsp_narrow_span),
      .rsp_longest_span  (rsp_longest_span)
   );

endmodule

// ===== hdl/bsst_ctrl.sv =====
// sequencer for load, check, scan, commit and reply of one beat
module bsst_ctrl
   import bsst_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   output logic          rsp_valid,
   input  bsst_stat_type stat,
   output bsst_cmd_type  cmd
);

   bsst_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (stat.full) begin
               state_in = ST_REPLY;
            end else if (stat.empty) begin
               state_in = ST_COMMIT;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (stat.last) state_in = ST_DRAIN;
         end
         ST_DRAIN:  state_in = ST_COMMIT;
         ST_COMMIT: state_in = ST_REPLY;
         ST_REPLY:  state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_CHECK:  cmd.check  = 1'b1;
         ST_SCAN:   cmd.scan   = 1'b1;
         ST_DRAIN:  cmd        = '0;
         ST_COMMIT: cmd.commit = 1'b1;
         ST_REPLY:  rsp_valid  = 1'b1;
         default:   cmd        = '0;
      endcase
   end

endmodule

// ===== hdl/bsst_dpath.sv =====
// value store, gap compare, min/max tracking and capacity register
module bsst_dpath
   import bsst_pkg::*;
#(
   parameter int MAX_ENTRIES = BSST_MAX_ENTRIES
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  bsst_cmd_type          cmd,
   output bsst_stat_type         stat,
   input  logic [BSST_VAL_W-1:0] req_value,
   input  logic                  req_start_new,
   input  logic                  csr_valid,
   input  logic [BSST_CAP_W-1:0] csr_capacity,
   output logic                  rsp_status,
   output logic [BSST_CAP_W-1:0] rsp_entries_held,
   output logic                  rsp_spans_valid,
   output logic [BSST_VAL_W-1:0] rsp_narrow_span,
   output logic [BSST_VAL_W-1:0] rsp_longest_span
);

   localparam int AW    = $clog2(MAX_ENTRIES);
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_W = (CNT_W > BSST_CAP_W) ? CNT_W : BSST_CAP_W;
   localparam logic [CMP_W-1:0] MAX_EXT = CMP_W'(MAX_ENTRIES);

   logic [BSST_VAL_W-1:0] mem_ff [MAX_ENTRIES];
   logic [BSST_VAL_W-1:0] rd_data_ff;
   logic                  rd_vld_ff;
   logic [BSST_VAL_W-1:0] value_ff;
   logic [BSST_CAP_W-1:0] cap_ff;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [BSST_VAL_W-1:0] min_ff, min_in;
   logic [BSST_VAL_W-1:0] max_ff, max_in;
   logic [BSST_VAL_W-1:0] gap_ff, gap_in;
   logic [AW-1:0]         idx_ff, idx_in;
   logic                  status_ff, status_in;

   logic [CMP_W-1:0]      cnt_ext;
   logic [CMP_W-1:0]      cap_ext;
   logic [CMP_W-1:0]      limit;
   logic                  full;
   logic                  ge;
   logic [BSST_VAL_W-1:0] gap_cand;

   assign cnt_ext = CMP_W'(count_ff);
   assign cap_ext = CMP_W'(cap_ff);
   assign limit   = (cap_ext < MAX_EXT) ? cap_ext : MAX_EXT;
   assign full    = (cnt_ext >= limit);

   assign stat.full  = full;
   assign stat.empty = (count_ff == '0);
   assign stat.last  = (CNT_W'(idx_ff) == count_ff - CNT_W'(1));

   // distance between the new value and one stored value
   assign ge       = ($signed(value_ff) >= $signed(rd_data_ff));
   assign gap_cand = ge ? (value_ff - rd_data_ff) : (rd_data_ff - value_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= BSST_CAP_RESET;
      end else if (csr_valid) begin
         cap_ff <= csr_capacity;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         mem_ff[count_ff[AW-1:0]] <= value_ff;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         value_ff <= req_value;
      end
   end

   always_comb begin
      count_in  = count_ff;
      min_in    = min_ff;
      max_in    = max_ff;
      gap_in    = gap_ff;
      idx_in    = idx_ff;
      status_in = status_ff;
      if (cmd.load && req_start_new) begin
         count_in = '0;
         min_in   = '0;
         max_in   = '0;
         gap_in   = '1;
      end
      if (cmd.check) begin
         status_in = full;
         idx_in    = '0;
      end
      if (cmd.scan) begin
         idx_in = idx_ff + AW'(1);
      end
      if (rd_vld_ff && (gap_cand < gap_ff)) begin
         gap_in = gap_cand;
      end
      if (cmd.commit) begin
         count_in = count_ff + CNT_W'(1);
         if (count_ff == '0) begin
            min_in = value_ff;
            max_in = value_ff;
         end else begin
            if ($signed(value_ff) < $signed(min_ff)) min_in = value_ff;
            if ($signed(value_ff) > $signed(max_ff)) max_in = value_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         min_ff    <= '0;
         max_ff    <= '0;
         gap_ff    <= '1;
         idx_ff    <= '0;
         status_ff <= 1'b0;
         rd_vld_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         min_ff    <= min_in;
         max_ff    <= max_in;
         gap_ff    <= gap_in;
         idx_ff    <= idx_in;
         status_ff <= status_in;
         rd_vld_ff <= cmd.scan;
      end
   end

   assign rsp_status       = status_ff;
   assign rsp_entries_held = cnt_ext[BSST_CAP_W-1:0];
   assign rsp_spans_valid  = (count_ff >= CNT_W'(2));
   assign rsp_narrow_span  = rsp_spans_valid ? gap_ff : '0;
   assign rsp_longest_span = rsp_spans_valid ? (max_ff - min_ff) : '0;

endmodule
